### hw/rtl/hwa_pkg.sv
`default_nettype none

package hwa_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int COS_ENTRIES_DEFAULT = 1024;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int FRAC_BITS       = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int KIND_WIDTH      = 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_KIND   = 2'd1;

   // window kinds, anything else is a full window
   localparam logic [KIND_WIDTH-1:0] KIND_FULL = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_RISE = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_FALL = 2'd2;

   localparam logic [CSR_DATA_WIDTH-1:0] LENGTH_RESET = 16'd256;

   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam longint unsigned ONE_Q30 = 64'd1073741824;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           restart;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] weighted;
      logic                           in_window;
      logic                           last;
   } rsp_type;

   // q1.15 cosine of a q30 angle, eleven taylor terms truncated per step, result rounded
   function automatic logic [15:0] cos_from_angle(longint unsigned angle);
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      longint unsigned rnd;
      x2   = (angle * angle) >> 30;
      term = ONE_Q30;
      acc  = longint'(ONE_Q30);
      term = ((term * x2) >> 30) / 2;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 12;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 30;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 56;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 90;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 132;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 182;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 240;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 306;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 380;
      acc  = acc + longint'(term);
      if (acc < 0) begin
         acc = 0;
      end
      rnd = (longint'(acc) + 64'd16384) >> 15;
      if (rnd > 64'd32768) begin
         rnd = 64'd32768;
      end
      return rnd[15:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/hann_window_applier.sv
// channel  | direction | signals                          | moves
// req      | in        | req_valid req_ready req_data     | one sample request
// rsp      | out       | rsp_valid rsp_ready rsp_data     | one weighted sample
// csr      | in        | csr_valid csr_ready csr_index/.. | register write, always ready
//
// a request inside the segment goes through the serial restoring divider
// that forms the 16-bit turn fraction, then the rom read, multiply, scale
// and output load states. a request past the segment goes straight to the
// output load. reset is synchronous, sets the csr registers to their reset
// values and clears position and handshake state. a stalled rsp holds the
// finished sample in the output register while the next request is already being worked on.
`default_nettype none

module hann_window_applier #(
   parameter int LENGTH_BITS = hwa_pkg::LENGTH_BITS_DEFAULT,
   parameter int COS_ENTRIES = hwa_pkg::COS_ENTRIES_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  hwa_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output hwa_pkg::rsp_type                      rsp_data,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [hwa_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire  [hwa_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import hwa_pkg::*;

   localparam int NW    = LENGTH_BITS + 1;        // numerator and divisor
   localparam int RW    = LENGTH_BITS + 2;        // partial remainder
   localparam int SW    = $clog2(FRAC_BITS + 1);
   localparam int IW    = $clog2(COS_ENTRIES + 1);
   localparam int PW    = FRAC_BITS - 2 + IW + 1;
   localparam int PRODW = 2 * SAMPLE_WIDTH + 1;
   localparam logic [SW-1:0] DIV_LAST = SW'(FRAC_BITS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_ROM,
      S_MUL,
      S_SCALE,
      S_EMIT
   } state_type;

   // quarter-wave cosine rom
   logic [15:0] cos_rom [COS_ENTRIES+1];
   for (genvar k = 0; k <= COS_ENTRIES; k++) begin : g_rom
      localparam longint unsigned ANGLE = PI_Q30 * longint'(k) / (2 * COS_ENTRIES);
      assign cos_rom[k] = cos_from_angle(ANGLE);
   end

   state_type                  state_ff, state_in;
   logic [CSR_DATA_WIDTH-1:0]  length_ff, length_in;
   logic [KIND_WIDTH-1:0]      kind_ff, kind_in;
   logic [LENGTH_BITS-1:0]     position_ff, position_in;
   logic                       done_ff, done_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;

   logic [RW-1:0]              rem_ff, rem_in;
   logic [NW-1:0]              den_ff, den_in;
   logic [FRAC_BITS-1:0]       quot_ff, quot_in;
   logic [SW-1:0]              step_ff, step_in;
   logic                       den_zero_ff, den_zero_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic                       last_ff, last_in;
   logic [15:0]                rom_q_ff, rom_q_in;
   logic                       neg_ff, neg_in;
   logic signed [PRODW-1:0]    prod_ff, prod_in;
   rsp_type                    res_ff, res_in;

   logic [LENGTH_BITS-1:0]     seg_len;
   logic [LENGTH_BITS-1:0]     pos_eff;
   logic                       done_eff;
   logic                       is_half;
   logic                       take_req;
   logic [RW-1:0]              trial;
   logic [FRAC_BITS-1:0]       frac;
   logic [PW-1:0]              idx_full;
   logic [IW-1:0]              idx;
   logic [IW-1:0]              rom_addr;
   logic [16:0]                w_sum;
   logic [15:0]                weight;
   logic signed [PRODW-1:0]    adj;
   logic signed [PRODW-1:0]    scaled;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign take_req  = req_valid && req_ready;

   assign seg_len  = LENGTH_BITS'(length_ff);
   assign pos_eff  = req_data.restart ? '0 : position_ff;
   assign done_eff = req_data.restart ? 1'b0 : done_ff;
   assign is_half  = (kind_ff == KIND_RISE) || (kind_ff == KIND_FALL);

   // first divider step compares without shifting
   assign trial = (step_ff == '0) ? rem_ff : {rem_ff[RW-2:0], 1'b0};

   // quarter-wave address from the turn fraction
   assign frac     = den_zero_ff ? '0 : quot_ff;
   assign idx_full = (PW'(frac[FRAC_BITS-3:0]) * PW'(COS_ENTRIES)
                      + PW'(1 << (FRAC_BITS - 3))) >> (FRAC_BITS - 2);
   assign idx      = (idx_full > PW'(COS_ENTRIES)) ? IW'(COS_ENTRIES) : idx_full[IW-1:0];
   assign rom_addr = frac[FRAC_BITS-2] ? (IW'(COS_ENTRIES) - idx) : idx;

   // weight = (1 - cos) / 2 in q1.15
   assign w_sum  = neg_ff ? (17'h08000 + {1'b0, rom_q_ff}) : (17'h08000 - {1'b0, rom_q_ff});
   assign weight = w_sum[16:1];

   // truncate toward zero
   assign adj    = prod_ff + (prod_ff[PRODW-1] ? PRODW'(32767) : PRODW'(0));
   assign scaled = adj >>> 15;

   always_comb begin
      state_in     = state_ff;
      length_in    = length_ff;
      kind_in      = kind_ff;
      position_in  = position_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      den_zero_in  = den_zero_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      rom_q_in     = rom_q_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: length_in = csr_wdata;
            CSR_WINDOW_KIND:   kind_in   = csr_wdata[KIND_WIDTH-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (take_req) begin
               sample_in = req_data.sample;
               if (done_eff || (pos_eff >= seg_len)) begin
                  done_in         = 1'b1;
                  position_in     = pos_eff;
                  res_in.weighted  = req_data.sample;
                  res_in.in_window = 1'b0;
                  res_in.last      = 1'b0;
                  state_in        = S_EMIT;
               end else begin
                  last_in = (pos_eff == seg_len - 1'b1);
                  if (pos_eff == seg_len - 1'b1) begin
                     done_in     = 1'b1;
                     position_in = pos_eff;
                  end else begin
                     done_in     = 1'b0;
                     position_in = pos_eff + 1'b1;
                  end
                  if (kind_ff == KIND_FALL) begin
                     rem_in = RW'(NW'(pos_eff) + NW'(seg_len) - 1'b1);
                  end else begin
                     rem_in = RW'(pos_eff);
                  end
                  if (is_half) begin
                     den_in = {seg_len - 1'b1, 1'b0};
                  end else begin
                     den_in = NW'(seg_len);
                  end
                  den_zero_in = is_half && (seg_len == LENGTH_BITS'(1));
                  step_in     = '0;
                  state_in    = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (trial >= RW'(den_ff)) begin
               rem_in  = trial - RW'(den_ff);
               quot_in = {quot_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               rem_in  = trial;
               quot_in = {quot_ff[FRAC_BITS-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = S_ROM;
            end
         end
         S_ROM: begin
            rom_q_in = cos_rom[rom_addr];
            // quadrants one and two give a negative cosine
            neg_in   = frac[FRAC_BITS-1] ^ frac[FRAC_BITS-2];
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = PRODW'(sample_ff) * PRODW'($signed({1'b0, weight}));
            state_in = S_SCALE;
         end
         S_SCALE: begin
            if (scaled > PRODW'(32767)) begin
               res_in.weighted = 16'sh7fff;
            end else if (scaled < -PRODW'(32768)) begin
               res_in.weighted = -16'sh8000;
            end else begin
               res_in.weighted = scaled[SAMPLE_WIDTH-1:0];
            end
            res_in.in_window = 1'b1;
            res_in.last      = last_ff;
            state_in         = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      quot_ff     <= quot_in;
      step_ff     <= step_in;
      den_zero_ff <= den_zero_in;
      sample_ff   <= sample_in;
      last_ff     <= last_in;
      rom_q_ff    <= rom_q_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         length_ff    <= LENGTH_RESET;
         kind_ff      <= KIND_FULL;
         position_ff  <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         kind_ff      <= kind_in;
         position_ff  <= position_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/hwa_checker.sv
`default_nettype none

module hwa_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  req_valid,
   input wire                                  req_ready,
   input hwa_pkg::req_type                     req_data,
   input wire                                  rsp_valid,
   input wire                                  rsp_ready,
   input hwa_pkg::rsp_type                     rsp_data,
   input wire                                  csr_valid,
   input wire                                  csr_ready,
   input wire [hwa_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input wire [hwa_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import hwa_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // one request at a time: busy right after a request is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // end of segment only inside the window
   a_last_in_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.in_window)
      else $error("last flagged outside the window");

   // reset leaves no result pending and the block open for requests
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state not cleared by reset");

endmodule

bind hann_window_applier hwa_checker u_hwa_checker (.*);

`default_nettype wire
